FILE: sv/mema_pkg.sv
// Package for the mean error metric accumulator.
// Shared widths, mode codes and the command type of the iterative divide/sqrt unit.
// No dependencies.
`default_nettype none
package mema_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int DATA_W = 16;
	localparam int MAG_W = 16;
	localparam int TERM_W = 2 * MAG_W;
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int SUM_W = 42;
	localparam int LOSS_W = 33;
	localparam int MODE_W = 2;

	// shared unit step counts
	localparam int DIV_STEPS = SUM_W;
	localparam int SQRT_STEPS = SUM_W / 2;
	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [MODE_W-1:0] MODE_MAE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MSE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RMSE = 2'd2;

	localparam int ADDR_W = 3;
	localparam logic REG_LOSS_MODE = 1'b0;

	typedef enum logic {
		OP_DIV,
		OP_SQRT
	} iter_op_t;

	typedef struct packed {
		logic start;
		iter_op_t op;
	} iter_cmd_t;

endpackage
`default_nettype wire

FILE: sv/mema_accum.sv
// Error accumulator: magnitude stage, squaring multiplier, saturating sum,
// element count and drop flag. Uses mema_pkg.
`default_nettype none
module mema_accum (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                load,
	input  wire logic signed [mema_pkg::DATA_W-1:0]  pred,
	input  wire logic signed [mema_pkg::DATA_W-1:0]  target,
	input  wire logic                                square,
	input  wire logic                                clear,
	output logic [mema_pkg::SUM_W-1:0]               sum,
	output logic [mema_pkg::CNT_W-1:0]               count,
	output logic                                     dropped
);

	logic signed [mema_pkg::DATA_W:0] diff;
	logic [mema_pkg::DATA_W:0] absd;
	logic [mema_pkg::MAG_W-1:0] mag_s1;
	logic sq_s1;
	logic vld_s1;
	logic [mema_pkg::TERM_W-1:0] term;
	logic [mema_pkg::SUM_W:0] sum_add;
	logic [mema_pkg::SUM_W-1:0] sum_q;
	logic [mema_pkg::CNT_W-1:0] count_q;
	logic dropped_q;
	logic room;

	assign diff = {pred[mema_pkg::DATA_W-1], pred} - {target[mema_pkg::DATA_W-1], target};
	assign absd = diff[mema_pkg::DATA_W] ? (~diff + 1'b1) : diff;

	assign term = sq_s1 ? (mag_s1 * mag_s1) : {{(mema_pkg::TERM_W - mema_pkg::MAG_W){1'b0}}, mag_s1};
	assign sum_add = {1'b0, sum_q} + {{(mema_pkg::SUM_W + 1 - mema_pkg::TERM_W){1'b0}}, term};
	assign room = (count_q < mema_pkg::CNT_W'(mema_pkg::MAX_ELEMENTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_s1 <= absd[mema_pkg::MAG_W-1:0];
			sq_s1 <= square;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
			dropped_q <= 1'b0;
		end else if (clear) begin
			sum_q <= '0;
			count_q <= '0;
			dropped_q <= 1'b0;
		end else if (vld_s1) begin
			if (room) begin
				// saturate on carry out
				sum_q <= sum_add[mema_pkg::SUM_W] ? '1 : sum_add[mema_pkg::SUM_W-1:0];
				count_q <= count_q + 1'b1;
			end else begin
				dropped_q <= 1'b1;
			end
		end
	end

	assign sum = sum_q;
	assign count = count_q;
	assign dropped = dropped_q;

endmodule
`default_nettype wire

FILE: sv/mema_iter.sv
// Shared iterative unit: restoring divide (one quotient bit a cycle) and
// digit-by-digit integer square root (one result bit a cycle) on one subtractor.
// Uses mema_pkg.
`default_nettype none
module mema_iter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mema_pkg::iter_cmd_t           cmd,
	input  wire logic [mema_pkg::SUM_W-1:0]    operand,
	input  wire logic [mema_pkg::CNT_W-1:0]    divisor,
	output logic                               done,
	output logic [mema_pkg::SUM_W-1:0]         result
);

	logic busy_q;
	logic done_q;
	logic [mema_pkg::STEP_W-1:0] cnt_q;
	mema_pkg::iter_op_t op_q;
	logic zdiv_q;
	logic [mema_pkg::SUM_W-1:0] val_q;
	logic [mema_pkg::CNT_W-1:0] rem_q;
	logic [mema_pkg::CNT_W-1:0] div_q;
	logic [mema_pkg::SUM_W-1:0] res_q;
	logic [mema_pkg::SUM_W-1:0] bit_q;

	logic [mema_pkg::CNT_W:0] partial;
	logic [mema_pkg::SUM_W:0] a_op;
	logic [mema_pkg::SUM_W:0] b_op;
	logic [mema_pkg::SUM_W:0] diff;
	logic ge;
	logic last_step;

	assign partial = {rem_q, val_q[mema_pkg::SUM_W-1]};

	always_comb begin
		if (op_q == mema_pkg::OP_DIV) begin
			a_op = {{(mema_pkg::SUM_W - mema_pkg::CNT_W){1'b0}}, partial};
			b_op = {{(mema_pkg::SUM_W + 1 - mema_pkg::CNT_W){1'b0}}, div_q};
		end else begin
			a_op = {1'b0, val_q};
			b_op = {1'b0, res_q} + {1'b0, bit_q};
		end
	end

	assign diff = a_op - b_op;
	assign ge = ~diff[mema_pkg::SUM_W];
	assign last_step = (op_q == mema_pkg::OP_DIV)
		? (cnt_q == mema_pkg::STEP_W'(mema_pkg::DIV_STEPS - 1))
		: (cnt_q == mema_pkg::STEP_W'(mema_pkg::SQRT_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= mema_pkg::OP_DIV;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= cmd.op;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			val_q <= operand;
			rem_q <= '0;
			res_q <= '0;
			div_q <= divisor;
			zdiv_q <= (divisor == '0);
			bit_q <= mema_pkg::SUM_W'(1) << (mema_pkg::SUM_W - 2);
		end else if (busy_q) begin
			if (op_q == mema_pkg::OP_DIV) begin
				val_q <= {val_q[mema_pkg::SUM_W-2:0], 1'b0};
				rem_q <= ge ? diff[mema_pkg::CNT_W-1:0] : partial[mema_pkg::CNT_W-1:0];
				res_q <= {res_q[mema_pkg::SUM_W-2:0], ge};
			end else begin
				if (ge) begin
					val_q <= diff[mema_pkg::SUM_W-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign done = done_q;
	// empty set yields zero
	assign result = (op_q == mema_pkg::OP_DIV && zdiv_q) ? '0 : res_q;

endmodule
`default_nettype wire

FILE: sv/mean_error_metric_accumulator.sv
// Mean error metric accumulator (MAE / MSE / RMSE), top level.
// Non-last item: input is ready again once the pair has passed magnitude/square and accumulate.
// Last item: the sum is divided by the count, for RMSE followed by a square root,
// all on the one shared subtract unit in mema_iter.
// Result held in an output register; a waiting result stalls only the next set's close.
// arst_n clears loss_mode, sum, count, drop flag, sequencer and output valid.
`default_nettype none
module mean_error_metric_accumulator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [mema_pkg::ADDR_W-1:0]         paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready,
	input  wire logic                                item_valid,
	output logic                                     item_ready,
	input  wire logic signed [mema_pkg::DATA_W-1:0]  pred,
	input  wire logic signed [mema_pkg::DATA_W-1:0]  target,
	input  wire logic                                last,
	output logic                                     result_valid,
	input  wire logic                                result_ready,
	output logic [mema_pkg::LOSS_W-1:0]              loss_value,
	output logic [mema_pkg::CNT_W-1:0]               element_count,
	output logic                                     overflow
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV_GO,
		ST_DIV,
		ST_SQRT_GO,
		ST_SQRT,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [mema_pkg::MODE_W-1:0] loss_mode_q;
	logic last_q;
	logic rmse_q;
	logic accept;
	logic square;
	logic clear;
	logic [mema_pkg::SUM_W-1:0] sum;
	logic [mema_pkg::CNT_W-1:0] count;
	logic dropped;
	mema_pkg::iter_cmd_t cmd;
	logic [mema_pkg::SUM_W-1:0] operand;
	logic iter_done;
	logic [mema_pkg::SUM_W-1:0] iter_result;
	logic result_valid_q;
	logic [mema_pkg::LOSS_W-1:0] loss_q;
	logic [mema_pkg::CNT_W-1:0] count_q;
	logic overflow_q;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_mode_q <= mema_pkg::MODE_MAE;
		end else if (psel && penable && pwrite && paddr[2] == mema_pkg::REG_LOSS_MODE) begin
			loss_mode_q <= pwdata[mema_pkg::MODE_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			mema_pkg::REG_LOSS_MODE: prdata = {{(32 - mema_pkg::MODE_W){1'b0}}, loss_mode_q};
			default: prdata = '0;
		endcase
	end

	assign item_ready = (state_q == ST_IDLE);
	assign accept = item_valid && item_ready;
	assign square = (loss_mode_q == mema_pkg::MODE_MSE) || (loss_mode_q == mema_pkg::MODE_RMSE);
	assign clear = (state_q == ST_FIN) && (!result_valid_q || result_ready);

	mema_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.pred    (pred),
		.target  (target),
		.square  (square),
		.clear   (clear),
		.sum     (sum),
		.count   (count),
		.dropped (dropped)
	);

	always_comb begin
		cmd.start = (state_q == ST_DIV_GO) || (state_q == ST_SQRT_GO);
		cmd.op = (state_q == ST_SQRT_GO) ? mema_pkg::OP_SQRT : mema_pkg::OP_DIV;
		operand = (state_q == ST_SQRT_GO) ? iter_result : sum;
	end

	mema_iter u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.operand (operand),
		.divisor (count),
		.done    (iter_done),
		.result  (iter_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q <= 1'b0;
			rmse_q <= 1'b0;
			result_valid_q <= 1'b0;
			loss_q <= '0;
			count_q <= '0;
			overflow_q <= 1'b0;
		end else begin
			// a new result loaded on the same edge keeps valid high
			if (result_valid_q && result_ready && !clear) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last;
						rmse_q <= (loss_mode_q == mema_pkg::MODE_RMSE);
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					state_q <= last_q ? ST_DIV_GO : ST_IDLE;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (iter_done) begin
						state_q <= rmse_q ? ST_SQRT_GO : ST_FIN;
					end
				end
				ST_SQRT_GO: begin
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (iter_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (clear) begin
						result_valid_q <= 1'b1;
						loss_q <= iter_result[mema_pkg::LOSS_W-1:0];
						count_q <= count;
						overflow_q <= dropped;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign loss_value = loss_q;
	assign element_count = count_q;
	assign overflow = overflow_q;

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for mean_error_metric_accumulator: MAE/MSE/RMSE over pair streams.
// Sends pairs over valid/ready, sets loss_mode over APB and compares results with a local
// predictor. Depends on mema_pkg and the block's RTL only.
`timescale 1ns / 100ps
module tb_top;
	import mema_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam logic [ADDR_W-1:0] ADDR_LOSS_MODE = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
	localparam bit [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
	localparam int SETTLE_CYCLES = 100;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [LOSS_W-1:0] loss;
		logic [CNT_W-1:0]  count;
		logic              ovf;
	} metric_t;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_W-1:0]        paddr;
	logic [31:0]              pwdata;
	logic [31:0]              prdata;
	logic                     pready;
	logic                     item_valid;
	logic                     item_ready;
	logic signed [DATA_W-1:0] pred;
	logic signed [DATA_W-1:0] target;
	logic                     item_last;
	logic                     result_valid;
	logic                     result_ready = 1'b0;
	logic [LOSS_W-1:0]        loss_value;
	logic [CNT_W-1:0]         element_count;
	logic                     overflow;

	// predictor state
	logic [MODE_W-1:0] cur_mode;
	bit [63:0]         acc_sum;
	int                acc_count;
	bit                acc_dropped;
	metric_t           pending_metrics[$];

	int err_count;
	int items_sent;
	int results_seen;
	int sender_gap_pct;
	int stall_pct;
	int cycle_cnt;
	int hold_until;

	logic [MODE_W-1:0] mode_choice[4] = '{MODE_MAE, MODE_MSE, MODE_RMSE, MODE_UNUSED};

	mean_error_metric_accumulator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.pred         (pred),
		.target       (target),
		.last         (item_last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.loss_value   (loss_value),
		.element_count(element_count),
		.overflow     (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("tb_top NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// output side: random stalls, plus a forced hold-off window
	always @(posedge clk) begin
		result_ready <= (cycle_cnt < hold_until) ? 1'b0 : ($urandom_range(99) >= stall_pct);
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	always @(posedge clk) begin : check_results
		metric_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (pending_metrics.size() == 0) begin
				report_mismatch($sformatf("unexpected result loss=%0d count=%0d ovf=%0d",
					loss_value, element_count, overflow));
			end else begin
				want = pending_metrics.pop_front();
				if (loss_value !== want.loss)
					report_mismatch($sformatf("loss_value %0d, want %0d", loss_value, want.loss));
				if (element_count !== want.count)
					report_mismatch($sformatf("element_count %0d, want %0d",
						element_count, want.count));
				if (overflow !== want.ovf)
					report_mismatch($sformatf("overflow %0d, want %0d", overflow, want.ovf));
			end
		end
	end

	function automatic bit [63:0] int_sqrt(input bit [63:0] v);
		bit [63:0] root;
		bit [63:0] trial;
		root = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// accumulate one accepted pair; close the set on last
	task automatic predict_pair(input logic signed [DATA_W-1:0] p,
			input logic signed [DATA_W-1:0] t, input logic l);
		longint    diff;
		bit [63:0] mag;
		bit [63:0] mean;
		bit        squared;
		metric_t   exp_r;
		diff = longint'(p) - longint'(t);
		mag = (diff < 0) ? -diff : diff;
		squared = (cur_mode == MODE_MSE) || (cur_mode == MODE_RMSE);
		if (acc_count < MAX_ELEMENTS) begin
			acc_sum = acc_sum + (squared ? mag * mag : mag);
			if (acc_sum > SUM_LIMIT)
				acc_sum = SUM_LIMIT;
			acc_count++;
		end else begin
			acc_dropped = 1'b1;
		end
		if (l) begin
			mean = (acc_count != 0) ? acc_sum / acc_count : 64'd0;
			if (cur_mode == MODE_RMSE)
				mean = int_sqrt(mean);
			exp_r.loss = mean[LOSS_W-1:0];
			exp_r.count = acc_count[CNT_W-1:0];
			exp_r.ovf = acc_dropped;
			pending_metrics.push_back(exp_r);
			acc_sum = 0;
			acc_count = 0;
			acc_dropped = 1'b0;
		end
	endtask

	task automatic send_item(input logic signed [DATA_W-1:0] p,
			input logic signed [DATA_W-1:0] t, input logic l);
		while ($urandom_range(99) < sender_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		pred <= p;
		target <= t;
		item_last <= l;
		do @(posedge clk); while (!item_ready);
		predict_pair(p, t, l);
		items_sent++;
	endtask

	// stop sending, wait for all results, then let the datapath settle
	task automatic drain_and_settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_metrics.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (addr == ADDR_LOSS_MODE)
			cur_mode = data[MODE_W-1:0];
	endtask

	task automatic check_loss_mode_readback();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_LOSS_MODE;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {{(32 - MODE_W){1'b0}}, cur_mode})
			report_mismatch($sformatf("loss_mode reads %0d, want %0d", prdata, cur_mode));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_loss_mode(input logic [MODE_W-1:0] m);
		drain_and_settle();
		apb_write(ADDR_LOSS_MODE, {{(32 - MODE_W){1'b0}}, m});
		check_loss_mode_readback();
	endtask

	task automatic set_idling(input int gap, input int stall);
		sender_gap_pct = gap;
		stall_pct <= stall;
	endtask

	function automatic logic signed [DATA_W-1:0] rand_q88();
		case ($urandom_range(7))
			0: return (($urandom_range(1) == 0) ? 16'sh8000 : 16'sh7FFF);
			1: return (($urandom_range(1) == 0) ? 16'sh0000 : 16'shFFFF);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// mode 0 must be in effect straight out of reset
	task automatic test_default_mode();
		send_item(16'sh7FFF, 16'sh8000, 1'b0);
		send_item(16'sh8000, 16'sh7FFF, 1'b1);
		drain_and_settle();
		check_loss_mode_readback();
	endtask

	task automatic test_each_mode();
		logic [MODE_W-1:0] order[4] = '{MODE_MSE, MODE_RMSE, MODE_UNUSED, MODE_MAE};
		foreach (order[i]) begin
			set_loss_mode(order[i]);
			send_item(16'sh8000, 16'sh7FFF, 1'b1);
			send_item(16'sh0100, 16'sh0080, 1'b0);
			send_item(16'shFFFF, 16'sh0000, 1'b0);
			send_item(16'sh0000, 16'sh0000, 1'b1);
		end
	endtask

	task automatic test_unmapped_register();
		set_loss_mode(MODE_MAE);
		apb_write(ADDR_UNMAPPED, {{(32 - MODE_W){1'b0}}, MODE_MSE});
		check_loss_mode_readback();
		send_item(16'sh0100, -16'sh0100, 1'b1);
	endtask

	// each pair uses the mode at its own transfer; the close uses the final mode
	task automatic test_mode_change_in_set();
		set_loss_mode(MODE_MAE);
		send_item(16'sh0200, 16'sh0000, 1'b0);
		set_loss_mode(MODE_MSE);
		send_item(16'sh0000, -16'sh0200, 1'b0);
		set_loss_mode(MODE_RMSE);
		send_item(16'sh03E8, -16'sh0BB8, 1'b1);
	endtask

	task automatic test_set_full();
		set_idling(0, 0);
		set_loss_mode(MODE_MSE);
		for (int i = 0; i < MAX_ELEMENTS + 5; i++)
			send_item(16'sh8000, 16'sh7FFF, i == MAX_ELEMENTS + 4);
		// next set must start clean
		set_loss_mode(MODE_MAE);
		send_item(16'sh0001, 16'sh0000, 1'b1);
	endtask

	task automatic test_random_sets(input int n_items);
		int budget;
		int len;
		budget = n_items;
		while (budget > 0) begin
			if ($urandom_range(3) == 0)
				set_loss_mode(mode_choice[$urandom_range(3)]);
			len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			if (len > budget)
				len = budget;
			for (int i = 0; i < len; i++)
				send_item(rand_q88(), rand_q88(), i == len - 1);
			budget -= len;
		end
	endtask

	// output held off long enough that a finished result backs up into the input
	task automatic test_output_hold_off();
		set_idling(0, 0);
		set_loss_mode(MODE_RMSE);
		hold_until <= cycle_cnt + HOLD_OFF_CYCLES;
		for (int i = 0; i < 20; i++)
			send_item(rand_q88(), rand_q88(), ($urandom_range(2) == 0) || (i == 19));
		drain_and_settle();
	endtask

	initial begin
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_valid <= 1'b0;
		pred <= '0;
		target <= '0;
		item_last <= 1'b0;
		arst_n <= 1'b0;
		cur_mode = MODE_MAE;
		acc_sum = 0;
		acc_count = 0;
		acc_dropped = 1'b0;
		err_count = 0;
		items_sent = 0;
		results_seen = 0;
		cycle_cnt = 0;
		hold_until = 0;
		sender_gap_pct = 0;
		stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_mode();
		test_each_mode();
		test_unmapped_register();
		test_mode_change_in_set();
		test_set_full();

		set_idling(0, 0);
		test_random_sets(100);
		set_idling(59, 0);
		test_random_sets(100);
		set_idling(0, 59);
		test_random_sets(100);
		set_idling(25, 25);
		test_random_sets(100);

		test_output_hold_off();

		drain_and_settle();
		$display("Covered %0d pair transfers and %0d results in MAE, MSE, RMSE and the unused mode,",
			items_sent, results_seen);
		$display("including a full set with dropped pairs, mid-set mode changes and output hold-off.");
		if (err_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
